### src/deterministic_primality_tester_assert.svh
// assertion macros for the primality tester
`ifndef DETERMINISTIC_PRIMALITY_TESTER_ASSERT_SVH
`define DETERMINISTIC_PRIMALITY_TESTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DPT_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DPT_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define DPT_ASSERT_IMPL(label, a, c)
`define DPT_ASSERT_NEXT(label, a, c)
`endif
`endif

### src/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg
// constants and command/status types of the primality tester
// ----------------------------------------------------------------------------
package dpt_pkg;
  localparam int N_BITS_DEF = 49;
  localparam longint unsigned SMALL_BOUND = 64'd4759123141;
  localparam longint unsigned LARGE_BOUND = 64'd341550071728321;
  localparam int BASE_W = 6;
  localparam int BIDX_W = 3;

  // base table: small set then large set
  function automatic logic [BASE_W-1:0] base_of(input logic big,
                                                input logic [BIDX_W-1:0] i);
    logic [BASE_W-1:0] b;
    b = 6'd2;
    if (!big) begin
      case (i)
        3'd0: b = 6'd2;
        3'd1: b = 6'd7;
        default: b = 6'd61;
      endcase
    end else begin
      case (i)
        3'd0: b = 6'd2;
        3'd1: b = 6'd3;
        3'd2: b = 6'd5;
        3'd3: b = 6'd7;
        3'd4: b = 6'd11;
        3'd5: b = 6'd13;
        default: b = 6'd17;
      endcase
    end
    return b;
  endfunction

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_BASE, OP_MULB, OP_SQ, OP_SQX
  } op_t;

  typedef struct packed {
    op_t op;
    logic [BIDX_W-1:0] bidx;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic e_bit;
    logic e_zero;
    logic x_one;
    logic x_nm1;
    logic base_zero;
    logic big_n;
    logic [6:0] s;
  } dp_sts_t;
endpackage

### src/dpt_if.sv
// ----------------------------------------------------------------------------
// dpt_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface dpt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/dpt_datapath.sv
// ----------------------------------------------------------------------------
// dpt_datapath
// modular arithmetic registers with a bit-serial shift-add multiplier
// ----------------------------------------------------------------------------
module dpt_datapath
  import dpt_pkg::*;
#(
  parameter int N_BITS = N_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [N_BITS-1:0] cand,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts
);
  localparam int CW = $clog2(N_BITS + 1);

  logic [N_BITS-1:0] n_r, d_r, e_r, x_r, b_r;
  logic [N_BITS-1:0] ma_r, mb_r, acc_r;
  logic [6:0]        s_r;
  logic              busy_r, dst_x_r, red_r;
  logic [CW-1:0]     cnt_r;

  // modular add of two values below n
  function automatic logic [N_BITS-1:0] addm(input logic [N_BITS-1:0] a,
                                             input logic [N_BITS-1:0] b,
                                             input logic [N_BITS-1:0] m);
    logic [N_BITS:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[N_BITS-1:0];
  endfunction

  logic [N_BITS-1:0] dm1, bval;
  logic              big_n;
  assign big_n = (n_r >= N_BITS'(SMALL_BOUND));

  always_comb begin
    dm1 = cand - N_BITS'(1);
    // raw base, reduced below n over the following cycles
    bval = N_BITS'(base_of(big_n, cmd.bidx));
  end

  // trailing zero count of n-1 (low bit of odd n is one)
  logic [6:0] tz1;
  always_comb begin
    tz1 = '0;
    for (int i = N_BITS - 1; i >= 1; i--) if (dm1[i]) tz1 = 7'(i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      red_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          n_r <= cand;
          s_r <= tz1;
          d_r <= dm1 >> tz1;
        end
        OP_BASE: begin
          b_r   <= bval;
          red_r <= 1'b1;
          x_r   <= N_BITS'(1);
          e_r   <= d_r;
        end
        OP_MULB, OP_SQ, OP_SQX: begin
          busy_r  <= 1'b1;
          cnt_r   <= '0;
          acc_r   <= '0;
          dst_x_r <= (cmd.op != OP_SQ);
          ma_r    <= (cmd.op == OP_MULB) ? b_r : ((cmd.op == OP_SQ) ? b_r : x_r);
          mb_r    <= (cmd.op == OP_MULB) ? x_r : ((cmd.op == OP_SQ) ? b_r : x_r);
          if (cmd.op == OP_SQ) e_r <= e_r >> 1;
        end
        default: ;
      endcase
      // reduce the base below n, one subtraction per cycle
      if (red_r) begin
        if (b_r >= n_r) b_r <= b_r - n_r;
        else red_r <= 1'b0;
      end
      // one multiplier bit per cycle
      if (busy_r) begin
        if (mb_r[0]) acc_r <= addm(acc_r, ma_r, n_r);
        ma_r  <= addm(ma_r, ma_r, n_r);
        mb_r  <= mb_r >> 1;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(N_BITS - 1)) begin
          busy_r <= 1'b0;
          if (dst_x_r) x_r <= mb_r[0] ? addm(acc_r, ma_r, n_r) : acc_r;
          else b_r <= mb_r[0] ? addm(acc_r, ma_r, n_r) : acc_r;
        end
      end
    end
  end

  assign sts.busy      = busy_r | red_r;
  assign sts.e_bit     = e_r[0];
  assign sts.e_zero    = (e_r == '0);
  assign sts.x_one     = (x_r == N_BITS'(1));
  assign sts.x_nm1     = (x_r == n_r - N_BITS'(1));
  assign sts.base_zero = (b_r == '0);
  assign sts.big_n     = big_n;
  assign sts.s         = s_r;
endmodule

### src/dpt_ctrl.sv
// ----------------------------------------------------------------------------
// dpt_ctrl
// sequencer for screening, bases, exponentiation and squaring rounds
// ----------------------------------------------------------------------------
module dpt_ctrl
  import dpt_pkg::*;
#(
  parameter int N_BITS = N_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [N_BITS-1:0] cand,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_prime,
  output logic              out_of_range,
  output dp_cmd_t           cmd,
  input  dp_sts_t           sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_CHK0, S_EXP, S_WMUL, S_WSQ, S_TEST, S_RSQ, S_RWAIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [6:0] r_r, r_nxt;
  logic out_valid_r, out_valid_nxt, prime_r, prime_nxt, oor_r, oor_nxt;

  always_comb begin
    state_nxt = state_r; bidx_nxt = bidx_r; r_nxt = r_r;
    out_valid_nxt = out_valid_r; prime_nxt = prime_r; oor_nxt = oor_r;
    cmd.op = OP_NONE; cmd.bidx = bidx_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid && (!out_valid_r || out_ready)) begin
        // screen trivial candidates
        if (64'(cand) >= LARGE_BOUND) begin
          out_valid_nxt = 1'b1; prime_nxt = 1'b0; oor_nxt = 1'b1;
        end else if (cand < N_BITS'(2) || !cand[0]) begin
          out_valid_nxt = 1'b1; prime_nxt = (cand == N_BITS'(2)); oor_nxt = 1'b0;
        end else begin
          cmd.op = OP_LOAD; bidx_nxt = '0; state_nxt = S_BASE;
        end
      end
      S_BASE: begin cmd.op = OP_BASE; state_nxt = S_CHK0; end
      // wait for the base reduction, skip a base that n divides
      S_CHK0: if (!sts.busy) state_nxt = sts.base_zero ? S_DONE : S_EXP;
      S_EXP: begin
        if (sts.e_zero) begin
          state_nxt = S_TEST;
        end else if (sts.e_bit) begin
          cmd.op = OP_MULB; state_nxt = S_WMUL;
        end else begin
          cmd.op = OP_SQ; state_nxt = S_WSQ;
        end
      end
      S_WMUL: if (!sts.busy) begin cmd.op = OP_SQ; state_nxt = S_WSQ; end
      S_WSQ: if (!sts.busy) state_nxt = S_EXP;
      S_TEST: begin
        r_nxt = 7'd1;
        if (sts.x_one || sts.x_nm1) state_nxt = S_DONE;
        else state_nxt = S_RSQ;
      end
      S_RSQ: begin
        if (r_r >= sts.s) begin
          // composite
          out_valid_nxt = 1'b1; prime_nxt = 1'b0; oor_nxt = 1'b0; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_SQX; state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: if (!sts.busy) begin
        r_nxt = r_r + 7'd1;
        state_nxt = sts.x_nm1 ? S_DONE : S_RSQ;
      end
      S_DONE: begin
        // base passed: next base or prime
        if (bidx_r == (sts.big_n ? 3'd6 : 3'd2)) begin
          out_valid_nxt = 1'b1; prime_nxt = 1'b1; oor_nxt = 1'b0; state_nxt = S_IDLE;
        end else begin
          bidx_nxt = bidx_r + 3'd1; state_nxt = S_BASE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0; bidx_r <= '0; r_r <= '0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt;
      bidx_r <= bidx_nxt; r_r <= r_nxt;
    end
    prime_r <= prime_nxt; oor_r <= oor_nxt;
  end

  assign in_ready     = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign is_prime     = prime_r;
  assign out_of_range = oor_r;
endmodule

### src/deterministic_primality_tester.sv
// ----------------------------------------------------------------------------
// deterministic_primality_tester
// deterministic miller-rabin test of one candidate per beat
// ----------------------------------------------------------------------------
// in: candidate beat (in_valid/in_ready). out: is_prime, out_of_range beat.
// candidates at or above 341550071728321 return out_of_range from the idle
// screen with no test run; 0, 1, 2 and even values are answered there too.
// odd candidates run 3 bases below 4759123141, else 7 bases; each base is
// reduced below n by repeated subtraction, then a square-and-multiply
// exponentiation plus up to s-1 squarings, every modular product going
// through the one bit-serial multiplier; at most about 96 products per
// base, so the multiplier work sets the test time.
// one candidate is in work at a time.
// the result holds in its register until taken; a new candidate is taken
// while the old result waits only if out_ready is high in that cycle.
// reset clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
`include "deterministic_primality_tester_assert.svh"
module deterministic_primality_tester
  import dpt_pkg::*;
#(
  parameter int N_BITS = N_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [N_BITS-1:0] in_candidate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_prime,
  output logic              out_of_range
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  dpt_ctrl #(.N_BITS(N_BITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .cand(in_candidate),
    .out_valid, .out_ready, .is_prime(out_is_prime), .out_of_range,
    .cmd, .sts
  );

  dpt_datapath #(.N_BITS(N_BITS)) u_dp (
    .clk, .rst_n, .cand(in_candidate), .cmd, .sts
  );

  `DPT_ASSERT_IMPL(a_oor_not_prime, out_valid && out_of_range, !out_is_prime)
  `DPT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_is_prime))
  `DPT_ASSERT_IMPL(a_no_mul_when_busy, sts.busy, cmd.op != OP_MULB && cmd.op != OP_SQX)
endmodule

### tb/deterministic_primality_tester_tb.sv
// ----------------------------------------------------------------------------
// deterministic_primality_tester_tb
// self-checking bench for the miller-rabin primality tester
// ----------------------------------------------------------------------------
// a directed table of candidates comes first: the trivial values, the range
// edges, bases equal to the candidate, and strong pseudoprimes. A random
// mix follows, mostly small odd values so the run stays short. Every result
// beat is compared in order against its typed verdict or the bench model of
// the test. Both handshakes idle at random, with calm stretches between.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module deterministic_primality_tester_tb;
  import dpt_pkg::*;

  localparam int NB = N_BITS_DEF;
  localparam int RANDOM_ITEMS = 80;
  localparam longint unsigned CYCLE_LIMIT = 64'd20000000;

  typedef struct packed {
    logic is_prime;
    logic oor;
  } verdict_t;

  typedef struct {
    longint unsigned cand;
    bit              typed;
    verdict_t        want;
  } row_t;

  logic clk;
  logic rst_n;
  bit   calm;
  int   err_cnt;
  longint unsigned cycle_cnt;
  verdict_t pending_verdicts[$];

  dpt_if #(.T(logic [NB-1:0])) cand_if ();
  dpt_if #(.T(verdict_t))      verdict_if ();

  deterministic_primality_tester #(.N_BITS(NB)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cand_if.valid),
    .in_ready    (cand_if.ready),
    .in_candidate(cand_if.data),
    .out_valid   (verdict_if.valid),
    .out_ready   (verdict_if.ready),
    .out_is_prime(verdict_if.data.is_prime),
    .out_of_range(verdict_if.data.oor)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // x*y mod m by shift and add, m below 2^62
  function automatic longint unsigned mod_product(longint unsigned x, longint unsigned y,
                                                  longint unsigned m);
    longint unsigned acc;
    acc = 0;
    x = x % m;
    y = y % m;
    while (y != 0) begin
      if (y[0]) begin
        acc = acc + x;
        if (acc >= m) acc = acc - m;
      end
      x = x + x;
      if (x >= m) x = x - m;
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned mod_power(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
    longint unsigned acc;
    acc = 1;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mod_product(acc, b, m);
      b = mod_product(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // base proves odd n composite
  function automatic bit proves_composite(longint unsigned a, longint unsigned n,
                                          longint unsigned d, int s);
    longint unsigned x;
    if (a % n == 0) return 1'b0;
    x = mod_power(a, d, n);
    if (x == 1 || x == n - 1) return 1'b0;
    for (int r = 1; r < s; r++) begin
      x = mod_product(x, x, n);
      if (x == n - 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t primality_of(longint unsigned cand);
    verdict_t v;
    longint unsigned n, d;
    longint unsigned few_bases[3] = '{2, 7, 61};
    longint unsigned many_bases[7] = '{2, 3, 5, 7, 11, 13, 17};
    int s;
    n = cand & ((64'd1 << NB) - 1);
    v = '0;
    if (n >= LARGE_BOUND) begin
      v.oor = 1'b1;
      return v;
    end
    if (n < 2) return v;
    if (n == 2) begin
      v.is_prime = 1'b1;
      return v;
    end
    if (!n[0]) return v;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    v.is_prime = 1'b1;
    if (n < SMALL_BOUND) begin
      foreach (few_bases[i])
        if (proves_composite(few_bases[i], n, d, s)) v.is_prime = 1'b0;
    end else begin
      foreach (many_bases[i])
        if (proves_composite(many_bases[i], n, d, s)) v.is_prime = 1'b0;
    end
    return v;
  endfunction

  // drive one candidate beat and log what it must produce
  task automatic send_candidate(longint unsigned cand, bit typed, verdict_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cand_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_if.valid <= 1'b1;
    cand_if.data  <= cand[NB-1:0];
    do @(posedge clk); while (!cand_if.ready);
    pending_verdicts.push_back(typed ? want : primality_of(cand));
  endtask

  // result side ready with random stalls
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      verdict_if.ready <= 1'b0;
      stall_left = 0;
    end else if (verdict_if.valid && verdict_if.ready) begin
      stall_left = calm ? 0 : $urandom_range(0, 4);
      verdict_if.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      verdict_if.ready <= (stall_left == 0);
    end else begin
      verdict_if.ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && verdict_if.valid && verdict_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected beat prime=%b oor=%b", $time,
                 verdict_if.data.is_prime, verdict_if.data.oor);
        err_cnt++;
      end else begin
        verdict_t w;
        w = pending_verdicts.pop_front();
        if (w.is_prime !== verdict_if.data.is_prime) begin
          $display("%0t: is_prime expected %b actual %b", $time, w.is_prime,
                   verdict_if.data.is_prime);
          err_cnt++;
        end
        if (w.oor !== verdict_if.data.oor) begin
          $display("%0t: out_of_range expected %b actual %b", $time, w.oor,
                   verdict_if.data.oor);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // directed rows: typed verdicts only where obvious
  row_t directed[] = '{
    '{64'd0, 1'b1, 2'b00},
    '{64'd1, 1'b1, 2'b00},
    '{64'd2, 1'b1, 2'b10},
    '{64'd4, 1'b1, 2'b00},
    '{64'd3, 1'b0, 2'b00},
    '{64'd7, 1'b0, 2'b00},
    '{64'd61, 1'b0, 2'b00},
    '{64'd9, 1'b0, 2'b00},
    '{64'd2047, 1'b0, 2'b00},
    '{64'd25326001, 1'b0, 2'b00},
    '{64'd3215031751, 1'b0, 2'b00},
    '{64'd4759123139, 1'b0, 2'b00},
    '{64'd4759123141, 1'b0, 2'b00},
    '{64'd341550071728319, 1'b0, 2'b00},
    '{64'd341550071728320, 1'b1, 2'b00},
    '{64'd341550071728321, 1'b1, 2'b01},
    '{64'd341550071728322, 1'b1, 2'b01},
    '{64'h1_FFFF_FFFF_FFFF, 1'b1, 2'b01},
    '{64'h1_5555_5555_5554, 1'b1, 2'b01},
    '{64'h0_AAAA_AAAA_AAAA, 1'b1, 2'b00}
  };

  // stimulus
  initial begin
    longint unsigned cand;
    int heavy_left;
    int guard;
    rst_n = 1'b0;
    calm = 1'b0;
    err_cnt = 0;
    cycle_cnt = 0;
    cand_if.valid = 1'b0;
    cand_if.data = '0;
    heavy_left = 2;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_candidate(directed[i].cand, directed[i].typed, directed[i].want);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 20 == 0) calm = (k % 40 == 20);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: cand = $urandom_range(0, 4095) | 1;
        5: cand = {$urandom, $urandom} & ((64'd1 << NB) - 1);
        6: cand = ({$urandom, $urandom} % LARGE_BOUND) & ~64'd1;
        7: cand = $urandom_range(0, 3);
        8: cand = $urandom_range(0, 1048575) | 1;
        default: begin
          if (heavy_left > 0) begin
            heavy_left--;
            cand = (SMALL_BOUND + {$urandom, $urandom} % (LARGE_BOUND - SMALL_BOUND)) | 1;
            if (cand >= LARGE_BOUND) cand = LARGE_BOUND - 2;
          end else begin
            cand = $urandom_range(0, 65535) | 1;
          end
        end
      endcase
      send_candidate(cand, 1'b0, '0);
    end
    cand_if.valid <= 1'b0;

    guard = 0;
    while (pending_verdicts.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### deterministic_primality_tester.f
+incdir+src
src/dpt_pkg.sv
src/dpt_if.sv
src/dpt_datapath.sv
src/dpt_ctrl.sv
src/deterministic_primality_tester.sv
tb/deterministic_primality_tester_tb.sv
